// ===== rtl/ptdq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdq_pkg
// shared sizes, operation and status codes for the position tracked deque
// ----------------------------------------------------------------------------
package ptdq_pkg;

   // queue depth must stay a power of two, the ring index wraps on its own
   localparam int QUEUE_DEPTH = 32;
   localparam int ID_COUNT    = 256;
   localparam int TAG_BITS    = 16;

   localparam int ID_W       = $clog2(ID_COUNT);
   localparam int HEAD_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W      = CNT_W;
   localparam int FUNC_W     = 3;
   localparam int ERR_W      = 2;
   localparam int NOTE_ID_W  = ID_W + 1;
   localparam int NOTE_POS_W = 7;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD_NEXT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_LAST    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP         = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GET_ORDER   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET_CURRENT = 3'd4;

   // status codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DUP   = 2'd3;

   // one entry of the per-id table: position (0 means not queued) and tag
   typedef struct packed {
      logic [POS_W-1:0]    pos;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

endpackage

// ===== rtl/ptdq_if.sv =====
// ----------------------------------------------------------------------------
// ptdq_if
// request and response channels of the position tracked deque
// ----------------------------------------------------------------------------
interface ptdq_req_if
   import ptdq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ID_W-1:0]     item_id;
   logic [TAG_BITS-1:0] item_tag;

   modport source (output valid, func, item_id, item_tag, input ready);
   modport sink   (input valid, func, item_id, item_tag, output ready);
endinterface

interface ptdq_rsp_if
   import ptdq_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [NOTE_ID_W-1:0] note_id;
   logic signed [NOTE_POS_W-1:0] note_position;
   logic [TAG_BITS-1:0]         note_tag;
   logic                        last;
   logic [ERR_W-1:0]            error;
   logic [CNT_W-1:0]            queue_count;
   logic signed [NOTE_ID_W-1:0] current_id;
   logic [TAG_BITS-1:0]         current_tag;

   modport source (output valid, note_id, note_position, note_tag, last, error,
                   queue_count, current_id, current_tag, input ready);
   modport sink   (input valid, note_id, note_position, note_tag, last, error,
                   queue_count, current_id, current_tag, output ready);
endinterface

// ===== rtl/position_tracked_deque_core.sv =====
// ----------------------------------------------------------------------------
// position_tracked_deque_core
// deque of item ids with a per-id position and tag table and a current id
// ----------------------------------------------------------------------------
// usage:
//   req carries one operation per beat (func, item_id, item_tag); it is taken
//   only while the sequencer is idle. rsp returns the notification beats the
//   operation causes, in queue order, with last set on the final beat.
//   a one-beat output register sits between the sequencer and rsp, so a new
//   request is taken while the final beat of the previous one still waits.
// sequence:
//   get_order, add_last and push rejects read the table, then stage their one
//   beat; pop on empty stages its status beat at accept. set_current gives a
//   second beat for the old id when one exists.
//   add_next and pop walk every queued entry through a three deep pipeline
//   (ring read, table read, table write and emit), one entry a cycle while rsp
//   is ready: add_next walks the whole queue after the push, pop the entries
//   left behind the popped id.
// reset:
//   synchronous, active high; queue empty, current id none, every table
//   entry reads as not queued with tag zero through per-id valid flops.
// stall:
//   while rsp holds a beat that is not taken, a walk with an entry in its last
//   stage holds, memory read registers keep their data, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module position_tracked_deque_core
   import ptdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ptdq_req_if.sink    req,
   ptdq_rsp_if.source  rsp
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_LOOK     = 7'b0000010,
      ST_POP_PT   = 7'b0000100,
      ST_EMIT     = 7'b0001000,
      ST_OLD_LOOK = 7'b0010000,
      ST_WALK     = 7'b0100000,
      ST_SPARE    = 7'b1000000
   } state_type;

   // sequencer and architectural state
   state_type                   state_ff, state_in;
   logic [HEAD_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [NOTE_ID_W-1:0] current_ff, current_in;
   logic [TAG_BITS-1:0]         cur_tag_ff, cur_tag_in;

   // latched request and old current id
   logic [FUNC_W-1:0]           func_ff, func_in;
   logic [ID_W-1:0]             id_ff, id_in;
   logic [TAG_BITS-1:0]         tag_ff, tag_in;
   logic signed [NOTE_ID_W-1:0] old_id_ff, old_id_in;
   logic [TAG_BITS-1:0]         old_tag_ff, old_tag_in;

   // staged single beat
   logic signed [NOTE_ID_W-1:0]  nt_id_ff, nt_id_in;
   logic signed [NOTE_POS_W-1:0] nt_pos_ff, nt_pos_in;
   logic [TAG_BITS-1:0]          nt_tag_ff, nt_tag_in;
   logic [ERR_W-1:0]             nt_err_ff, nt_err_in;
   logic                         nt_last_ff, nt_last_in;
   state_type                    after_ff, after_in;

   // walk pipeline
   logic [CNT_W-1:0]  rd_k_ff, rd_k_in;
   logic              s1_v_ff, s1_v_in;
   logic [POS_W-1:0]  s1_pos_ff, s1_pos_in;
   logic              s2_v_ff, s2_v_in;
   logic [POS_W-1:0]  s2_pos_ff, s2_pos_in;
   logic [ID_W-1:0]   s2_id_ff, s2_id_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [NOTE_ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic signed [NOTE_POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [TAG_BITS-1:0]          rsp_tag_ff, rsp_tag_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [ERR_W-1:0]             rsp_err_ff, rsp_err_in;
   logic [CNT_W-1:0]             rsp_cnt_ff, rsp_cnt_in;
   logic signed [NOTE_ID_W-1:0]  rsp_cur_ff, rsp_cur_in;
   logic [TAG_BITS-1:0]          rsp_cur_tag_ff, rsp_cur_tag_in;

   // ring of queued ids, reset undefined
   logic [ID_W-1:0]   ring_mem [QUEUE_DEPTH];
   logic [ID_W-1:0]   ring_q;
   logic              ring_re, ring_we;
   logic [HEAD_W-1:0] ring_ra, ring_wa;
   logic [ID_W-1:0]   ring_wd;

   // per-id position and tag table, valid flop per id stands for reset zero
   entry_type         pt_mem [ID_COUNT];
   entry_type         pt_q;
   logic              pt_vq;
   logic [ID_COUNT-1:0] pt_valid_ff;
   logic              pt_re, pt_we;
   logic [ID_W-1:0]   pt_ra, pt_wa;
   entry_type         pt_wd;
   entry_type         pt_eff;
   logic signed [NOTE_POS_W-1:0] pt_pos_note;

   // beat staging and emission requests
   logic                         stage_now;
   logic signed [NOTE_ID_W-1:0]  st_id;
   logic signed [NOTE_POS_W-1:0] st_pos;
   logic [TAG_BITS-1:0]          st_tag;
   logic [ERR_W-1:0]             st_err;
   logic                         st_last;
   state_type                    st_after;

   logic                         emit_now;
   logic signed [NOTE_ID_W-1:0]  em_id;
   logic signed [NOTE_POS_W-1:0] em_pos;
   logic [TAG_BITS-1:0]          em_tag;
   logic [ERR_W-1:0]             em_err;
   logic                         em_last;

   logic req_fire;
   logic slot_free;
   logic adv;
   logic walk_last;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // unwritten table entries read as zero
   assign pt_eff      = pt_vq ? pt_q : '0;
   assign pt_pos_note = (pt_eff.pos == '0) ? '1 : NOTE_POS_W'(pt_eff.pos);
   assign walk_last   = (s2_pos_ff == count_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      current_in = current_ff;
      cur_tag_in = cur_tag_ff;
      func_in    = func_ff;
      id_in      = id_ff;
      tag_in     = tag_ff;
      old_id_in  = old_id_ff;
      old_tag_in = old_tag_ff;
      nt_id_in   = nt_id_ff;
      nt_pos_in  = nt_pos_ff;
      nt_tag_in  = nt_tag_ff;
      nt_err_in  = nt_err_ff;
      nt_last_in = nt_last_ff;
      after_in   = after_ff;
      rd_k_in    = rd_k_ff;
      s1_v_in    = s1_v_ff;
      s1_pos_in  = s1_pos_ff;
      s2_v_in    = s2_v_ff;
      s2_pos_in  = s2_pos_ff;
      s2_id_in   = s2_id_ff;

      ring_re = 1'b0;
      ring_ra = head_ff;
      ring_we = 1'b0;
      ring_wa = head_ff;
      ring_wd = id_ff;
      pt_re   = 1'b0;
      pt_ra   = id_ff;
      pt_we   = 1'b0;
      pt_wa   = id_ff;
      pt_wd   = '0;

      stage_now = 1'b0;
      st_id     = NOTE_ID_W'(id_ff);
      st_pos    = pt_pos_note;
      st_tag    = pt_eff.tag;
      st_err    = ERR_OK;
      st_last   = 1'b1;
      st_after  = ST_IDLE;

      emit_now = 1'b0;
      em_id    = nt_id_ff;
      em_pos   = nt_pos_ff;
      em_tag   = nt_tag_ff;
      em_err   = nt_err_ff;
      em_last  = nt_last_ff;

      adv = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in = req.func;
               id_in   = req.item_id;
               tag_in  = req.item_tag;
               unique case (req.func)
                  FUNC_ADD_NEXT, FUNC_ADD_LAST, FUNC_GET_ORDER, FUNC_SET_CURRENT: begin
                     pt_re    = 1'b1;
                     pt_ra    = req.item_id;
                     state_in = ST_LOOK;
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        // pop on empty: one status beat, nothing changes
                        stage_now = 1'b1;
                        st_id     = '1;
                        st_pos    = '1;
                        st_tag    = '0;
                        st_err    = ERR_EMPTY;
                     end else begin
                        ring_re  = 1'b1;
                        ring_ra  = head_ff;
                        state_in = ST_LOOK;
                     end
                  end
                  default: begin
                     // unknown operation is dropped
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_LOOK: begin
            unique case (func_ff)
               FUNC_ADD_NEXT, FUNC_ADD_LAST: begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     stage_now = 1'b1;
                     st_err    = ERR_FULL;
                  end else if (pt_eff.pos != '0) begin
                     stage_now = 1'b1;
                     st_err    = ERR_DUP;
                  end else if (func_ff == FUNC_ADD_LAST) begin
                     ring_we   = 1'b1;
                     ring_wa   = head_ff + count_ff[HEAD_W-1:0];
                     ring_wd   = id_ff;
                     count_in  = count_ff + CNT_W'(1);
                     pt_we     = 1'b1;
                     pt_wa     = id_ff;
                     pt_wd.pos = count_ff + CNT_W'(1);
                     pt_wd.tag = tag_ff;
                     stage_now = 1'b1;
                     st_pos    = NOTE_POS_W'(count_ff + CNT_W'(1));
                     st_tag    = tag_ff;
                  end else begin
                     // push front, then renumber the whole queue
                     head_in   = head_ff - HEAD_W'(1);
                     ring_we   = 1'b1;
                     ring_wa   = head_ff - HEAD_W'(1);
                     ring_wd   = id_ff;
                     count_in  = count_ff + CNT_W'(1);
                     pt_we     = 1'b1;
                     pt_wa     = id_ff;
                     pt_wd.pos = '0;
                     pt_wd.tag = tag_ff;
                     rd_k_in   = '0;
                     s1_v_in   = 1'b0;
                     s2_v_in   = 1'b0;
                     state_in  = ST_WALK;
                  end
               end
               FUNC_GET_ORDER: begin
                  stage_now = 1'b1;
               end
               FUNC_SET_CURRENT: begin
                  current_in = NOTE_ID_W'(id_ff);
                  cur_tag_in = tag_ff;
                  old_id_in  = current_ff;
                  old_tag_in = cur_tag_ff;
                  // fetch the old id's entry for the second beat
                  pt_re      = 1'b1;
                  pt_ra      = current_ff[ID_W-1:0];
                  stage_now  = 1'b1;
                  st_tag     = tag_ff;
                  st_last    = current_ff[NOTE_ID_W-1];
                  st_after   = current_ff[NOTE_ID_W-1] ? ST_IDLE : ST_OLD_LOOK;
               end
               FUNC_POP: begin
                  // ring data holds the front id
                  pt_re    = 1'b1;
                  pt_ra    = ring_q;
                  state_in = ST_POP_PT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_POP_PT: begin
            pt_we     = 1'b1;
            pt_wa     = ring_q;
            pt_wd.pos = '0;
            pt_wd.tag = pt_eff.tag;
            head_in   = head_ff + HEAD_W'(1);
            count_in  = count_ff - CNT_W'(1);
            rd_k_in   = '0;
            s1_v_in   = 1'b0;
            s2_v_in   = 1'b0;
            stage_now = 1'b1;
            st_id     = NOTE_ID_W'(ring_q);
            st_pos    = '1;
            st_last   = (count_ff == CNT_W'(1));
            st_after  = (count_ff == CNT_W'(1)) ? ST_IDLE : ST_WALK;
         end

         ST_EMIT: begin
            if (slot_free) begin
               emit_now = 1'b1;
               state_in = after_ff;
            end
         end

         ST_OLD_LOOK: begin
            stage_now = 1'b1;
            st_id     = old_id_ff;
            st_tag    = old_tag_ff;
         end

         ST_WALK: begin
            adv = !s2_v_ff || slot_free;
            if (adv) begin
               // stage 0: ring read of the next entry
               if (rd_k_ff != count_ff) begin
                  ring_re   = 1'b1;
                  ring_ra   = head_ff + rd_k_ff[HEAD_W-1:0];
                  s1_v_in   = 1'b1;
                  s1_pos_in = rd_k_ff + CNT_W'(1);
                  rd_k_in   = rd_k_ff + CNT_W'(1);
               end else begin
                  s1_v_in = 1'b0;
               end
               // stage 1: table read at the id just fetched
               s2_v_in = s1_v_ff;
               if (s1_v_ff) begin
                  pt_re     = 1'b1;
                  pt_ra     = ring_q;
                  s2_pos_in = s1_pos_ff;
                  s2_id_in  = ring_q;
               end
               // stage 2: new position written back and emitted
               if (s2_v_ff) begin
                  pt_we     = 1'b1;
                  pt_wa     = s2_id_ff;
                  pt_wd.pos = s2_pos_ff;
                  pt_wd.tag = pt_eff.tag;
                  emit_now  = 1'b1;
                  em_id     = NOTE_ID_W'(s2_id_ff);
                  em_pos    = NOTE_POS_W'(s2_pos_ff);
                  em_tag    = pt_eff.tag;
                  em_err    = ERR_OK;
                  em_last   = walk_last;
                  if (walk_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (stage_now) begin
         nt_id_in   = st_id;
         nt_pos_in  = st_pos;
         nt_tag_in  = st_tag;
         nt_err_in  = st_err;
         nt_last_in = st_last;
         after_in   = st_after;
         state_in   = ST_EMIT;
      end
   end

   // output register: count and current id are already updated at emit time
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_id_in      = rsp_id_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_cur_in     = rsp_cur_ff;
      rsp_cur_tag_in = rsp_cur_tag_ff;
      if (emit_now) begin
         rsp_valid_in   = 1'b1;
         rsp_id_in      = em_id;
         rsp_pos_in     = em_pos;
         rsp_tag_in     = em_tag;
         rsp_last_in    = em_last;
         rsp_err_in     = em_err;
         rsp_cnt_in     = count_ff;
         rsp_cur_in     = current_ff;
         rsp_cur_tag_in = cur_tag_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         current_ff   <= '1;
         cur_tag_ff   <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         cur_tag_ff   <= cur_tag_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      id_ff          <= id_in;
      tag_ff         <= tag_in;
      old_id_ff      <= old_id_in;
      old_tag_ff     <= old_tag_in;
      nt_id_ff       <= nt_id_in;
      nt_pos_ff      <= nt_pos_in;
      nt_tag_ff      <= nt_tag_in;
      nt_err_ff      <= nt_err_in;
      nt_last_ff     <= nt_last_in;
      after_ff       <= after_in;
      rd_k_ff        <= rd_k_in;
      s1_pos_ff      <= s1_pos_in;
      s2_pos_ff      <= s2_pos_in;
      s2_id_ff       <= s2_id_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_cur_ff     <= rsp_cur_in;
      rsp_cur_tag_ff <= rsp_cur_tag_in;
   end

   // ring memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= ring_wd;
      end
      if (ring_re) begin
         ring_q <= ring_mem[ring_ra];
      end
   end

   // id table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      if (pt_re) begin
         pt_q  <= pt_mem[pt_ra];
         pt_vq <= pt_valid_ff[pt_ra];
      end
   end

   // an entry turns valid at its first write
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= '0;
      end else if (pt_we) begin
         pt_valid_ff[pt_wa] <= 1'b1;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.note_id       = rsp_id_ff;
   assign rsp.note_position = rsp_pos_ff;
   assign rsp.note_tag      = rsp_tag_ff;
   assign rsp.last          = rsp_last_ff;
   assign rsp.error         = rsp_err_ff;
   assign rsp.queue_count   = rsp_cnt_ff;
   assign rsp.current_id    = rsp_cur_ff;
   assign rsp.current_tag   = rsp_cur_tag_ff;

endmodule

// ===== verif/ptdq_note_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptdq_note_checker
// watches both channels of the deque, predicts the notification beats of
// every accepted request and compares them in order with the beats returned
// ----------------------------------------------------------------------------
module ptdq_note_checker
   import ptdq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ptdq_req_if  req,
   ptdq_rsp_if  rsp,
   output int   fail_count,
   output int   pending,
   output int   requests_seen,
   output int   beats_seen,
   output int   empty_pops,
   output int   full_pushes,
   output int   repeat_pushes
);

   typedef struct packed {
      logic [NOTE_ID_W-1:0]  note_id;
      logic [NOTE_POS_W-1:0] note_pos;
      logic [TAG_BITS-1:0]   note_tag;
      logic                  last;
      logic [ERR_W-1:0]      error;
      logic [CNT_W-1:0]      count;
      logic [NOTE_ID_W-1:0]  cur_id;
      logic [TAG_BITS-1:0]   cur_tag;
   } note_beat_type;

   localparam int REPORT_MAX = 10;

   // model of the deque
   logic [ID_W-1:0]     ring_slot [QUEUE_DEPTH];
   logic [HEAD_W-1:0]   front_ptr;
   int                  used;
   int                  order_of [ID_COUNT];
   logic [TAG_BITS-1:0] tag_of [ID_COUNT];
   int                  cur_sel;
   logic [TAG_BITS-1:0] cur_sel_tag;

   note_beat_type expected_notes[$];
   int bad_beats, req_cnt, beat_cnt, n_empty, n_full, n_repeat;

   function automatic int order_or_none(int id);
      return (order_of[id] == 0) ? -1 : order_of[id];
   endfunction

   function automatic void add_note(int id, int ord, logic [TAG_BITS-1:0] tag,
                                    logic [ERR_W-1:0] err);
      note_beat_type b;
      b.note_id  = NOTE_ID_W'(id);
      b.note_pos = NOTE_POS_W'(ord);
      b.note_tag = tag;
      b.last     = 1'b0;
      b.error    = err;
      b.count    = CNT_W'(used);
      b.cur_id   = NOTE_ID_W'(cur_sel);
      b.cur_tag  = cur_sel_tag;
      expected_notes.insert(expected_notes.size(), b);
   endfunction

   function automatic void predict_notes(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [TAG_BITS-1:0] tag);
      int first;
      int k;
      int old_id;
      logic [TAG_BITS-1:0] old_tag;
      logic [ID_W-1:0] front;
      first = expected_notes.size();
      case (op)
         FUNC_ADD_NEXT, FUNC_ADD_LAST: begin
            if (used >= QUEUE_DEPTH) begin
               n_full++;
               add_note(int'(id), order_or_none(int'(id)), tag_of[id], ERR_FULL);
            end else if (order_of[id] != 0) begin
               n_repeat++;
               add_note(int'(id), order_or_none(int'(id)), tag_of[id], ERR_DUP);
            end else begin
               tag_of[id] = tag;
               if (op == FUNC_ADD_NEXT) begin
                  front_ptr = front_ptr - HEAD_W'(1);
                  ring_slot[front_ptr] = id;
                  used++;
                  for (k = 0; k < used; k++)
                     order_of[ring_slot[front_ptr + HEAD_W'(k)]] = k + 1;
                  for (k = 0; k < used; k++) begin
                     front = ring_slot[front_ptr + HEAD_W'(k)];
                     add_note(int'(front), order_or_none(int'(front)), tag_of[front], ERR_OK);
                  end
               end else begin
                  ring_slot[front_ptr + HEAD_W'(used)] = id;
                  used++;
                  order_of[id] = used;
                  add_note(int'(id), used, tag, ERR_OK);
               end
            end
         end
         FUNC_POP: begin
            if (used == 0) begin
               n_empty++;
               add_note(-1, -1, '0, ERR_EMPTY);
            end else begin
               front = ring_slot[front_ptr];
               front_ptr = front_ptr + HEAD_W'(1);
               used--;
               order_of[front] = 0;
               for (k = 0; k < used; k++)
                  order_of[ring_slot[front_ptr + HEAD_W'(k)]] = k + 1;
               add_note(int'(front), -1, tag_of[front], ERR_OK);
               for (k = 0; k < used; k++) begin
                  front = ring_slot[front_ptr + HEAD_W'(k)];
                  add_note(int'(front), order_or_none(int'(front)), tag_of[front], ERR_OK);
               end
            end
         end
         FUNC_GET_ORDER: add_note(int'(id), order_or_none(int'(id)), tag_of[id], ERR_OK);
         FUNC_SET_CURRENT: begin
            old_id = cur_sel;
            old_tag = cur_sel_tag;
            cur_sel = int'(id);
            cur_sel_tag = tag;
            add_note(int'(id), order_or_none(int'(id)), tag, ERR_OK);
            if (old_id >= 0)
               add_note(old_id, order_or_none(old_id), old_tag, ERR_OK);
         end
         default: ;
      endcase
      if (expected_notes.size() > first) begin
         req_cnt++;
         expected_notes[expected_notes.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic show_beat(string what, note_beat_type b);
      $display("  %s: id=%0d pos=%0d tag=%h last=%b err=%0d count=%0d cur=%0d cur_tag=%h",
               what, $signed(b.note_id), $signed(b.note_pos), b.note_tag, b.last,
               b.error, b.count, $signed(b.cur_id), b.cur_tag);
   endtask

   always @(posedge clock) begin
      note_beat_type got;
      note_beat_type want;
      if (reset) begin
         expected_notes.delete();
         front_ptr = '0;
         used = 0;
         cur_sel = -1;
         cur_sel_tag = '0;
         for (int i = 0; i < ID_COUNT; i++) begin
            order_of[i] = 0;
            tag_of[i] = '0;
         end
         bad_beats = 0;
         req_cnt = 0;
         beat_cnt = 0;
         n_empty = 0;
         n_full = 0;
         n_repeat = 0;
      end else begin
         // returned beats belong to earlier requests, so check before predicting
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.note_id, rsp.note_position, rsp.note_tag, rsp.last, rsp.error,
                    rsp.queue_count, rsp.current_id, rsp.current_tag};
            beat_cnt++;
            if (expected_notes.size() == 0) begin
               bad_beats++;
               if (bad_beats <= REPORT_MAX) begin
                  $display("%0t: beat %0d arrived with nothing outstanding", $realtime,
                           beat_cnt);
                  show_beat("actual", got);
               end
            end else begin
               want = expected_notes.pop_front();
               if (got !== want) begin
                  bad_beats++;
                  if (bad_beats <= REPORT_MAX) begin
                     $display("%0t: beat %0d differs", $realtime, beat_cnt);
                     show_beat("expected", want);
                     show_beat("actual", got);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            predict_notes(req.func, req.item_id, req.item_tag);
      end
      fail_count    <= bad_beats;
      pending       <= expected_notes.size();
      requests_seen <= req_cnt;
      beats_seen    <= beat_cnt;
      empty_pops    <= n_empty;
      full_pushes   <= n_full;
      repeat_pushes <= n_repeat;
   end

endmodule

// ===== verif/position_tracked_deque_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_tracked_deque_core_test
// drives directed and random deque operations with random idling on both
// channels; a checker beside the block predicts and compares every beat
// ----------------------------------------------------------------------------
module position_tracked_deque_core_test;
   import ptdq_pkg::*;

   // codes the block ignores
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 58;
   localparam int DRAIN_WAIT  = 60;    // trailing cycles, beyond a full walk
   localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side

   logic clock = 1'b0;
   logic reset;
   logic sink_ready;
   logic calm;
   int   hold;
   int   quiet;

   int fail_count, pending, requests_seen, beats_seen;
   int empty_pops, full_pushes, repeat_pushes;

   ptdq_req_if req();
   ptdq_rsp_if rsp();

   position_tracked_deque_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   ptdq_note_checker watch (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending       (pending),
      .requests_seen (requests_seen),
      .beats_seen    (beats_seen),
      .empty_pops    (empty_pops),
      .full_pushes   (full_pushes),
      .repeat_pushes (repeat_pushes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   assign rsp.ready = sink_ready;

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver side: ready held at a random level for a random run of cycles
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         hold <= 0;
      end else if (hold != 0) begin
         hold <= hold - 1;
      end else if (calm) begin
         sink_ready <= 1'b1;
      end else begin
         sink_ready <= ($urandom_range(0, 99) < 65);
         hold <= gap_len();
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // one request beat, held until taken
   task automatic send_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                          logic [TAG_BITS-1:0] tag);
      req.valid    <= 1'b1;
      req.func     <= f;
      req.item_id  <= id;
      req.item_tag <= tag;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic rest(int n);
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // fill mode leans on pushes so the queue reaches full, drain mode on pops
   function automatic logic [FUNC_W-1:0] pick_func(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (r < 45) return FUNC_ADD_NEXT;
            if (r < 80) return FUNC_ADD_LAST;
            if (r < 88) return FUNC_POP;
            if (r < 94) return FUNC_GET_ORDER;
            return FUNC_SET_CURRENT;
         end
         1: begin
            if (r < 15) return FUNC_ADD_NEXT;
            if (r < 25) return FUNC_ADD_LAST;
            if (r < 80) return FUNC_POP;
            if (r < 90) return FUNC_GET_ORDER;
            return FUNC_SET_CURRENT;
         end
         default: begin
            if (r < 20) return FUNC_ADD_NEXT;
            if (r < 40) return FUNC_ADD_LAST;
            if (r < 65) return FUNC_POP;
            if (r < 85) return FUNC_GET_ORDER;
            return FUNC_SET_CURRENT;
         end
      endcase
   endfunction

   // a small pool of ids makes repeated pushes and hits on queued ids common
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 99) < 60) return ID_W'($urandom_range(0, 47));
      return ID_W'($urandom_range(0, ID_COUNT - 1));
   endfunction

   function automatic logic [TAG_BITS-1:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return TAG_BITS'($urandom_range(0, 65535));
   endfunction

   initial begin
      int phase;
      int n;
      reset        <= 1'b1;
      calm         <= 1'b0;
      req.valid    <= 1'b0;
      req.func     <= FUNC_GET_ORDER;
      req.item_id  <= '0;
      req.item_tag <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, current id with and without an old one,
      // both push kinds at the id and tag extremes, repeated ids, ignored codes
      send_op(FUNC_POP, 8'd0, 16'h0000);
      send_op(FUNC_GET_ORDER, 8'd255, 16'h0000);
      send_op(FUNC_SET_CURRENT, 8'd0, 16'hffff);
      rest(gap_len());
      send_op(FUNC_SET_CURRENT, 8'd255, 16'h0000);
      send_op(FUNC_ADD_NEXT, 8'd0, 16'h0000);
      send_op(FUNC_ADD_NEXT, 8'd255, 16'hffff);
      rest(gap_len());
      send_op(FUNC_ADD_LAST, 8'd170, 16'h5555);
      send_op(FUNC_ADD_LAST, 8'd85, 16'haaaa);
      send_op(FUNC_ADD_NEXT, 8'd0, 16'h1111);
      send_op(FUNC_ADD_LAST, 8'd255, 16'h2222);
      send_op(FUNC_GET_ORDER, 8'd85, 16'h0000);
      send_op(FUNC_SPARE_LO, 8'd255, 16'hffff);
      send_op(FUNC_SPARE_MID, 8'd1, 16'h0001);
      send_op(FUNC_SPARE_HI, 8'd0, 16'h0000);
      send_op(FUNC_POP, 8'd0, 16'h0000);
      rest(gap_len());
      // popped id keeps its tag
      send_op(FUNC_GET_ORDER, 8'd255, 16'h0000);
      send_op(FUNC_SET_CURRENT, 8'd170, 16'h1234);
      send_op(FUNC_POP, 8'd0, 16'h0000);
      send_op(FUNC_POP, 8'd0, 16'h0000);
      send_op(FUNC_POP, 8'd0, 16'h0000);
      send_op(FUNC_POP, 8'd0, 16'h0000);

      // random phases: fill, drain, mixed; every fourth phase without idling
      for (phase = 0; phase < PHASES; phase++) begin
         calm <= (phase % 4 == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 3)
               send_op(FUNC_W'($urandom_range(int'(FUNC_SPARE_LO), int'(FUNC_SPARE_HI))),
                       pick_id(), pick_tag());
            send_op(pick_func(phase % 3), pick_id(), pick_tag());
            if (phase % 4 != 3) rest(gap_len());
         end
      end
      req.valid <= 1'b0;
      calm <= 1'b0;

      // let the checker see the last request before looking at what is left
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("ran %0d requests giving %0d notification beats", requests_seen, beats_seen);
      $display("rejects seen: %0d pops on empty, %0d pushes to full, %0d repeated ids",
               empty_pops, full_pushes, repeat_pushes);
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
